FILE: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Holds the framing constants, config register codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	// framing bytes
	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] SECOND_BYTE = 8'hAA;

	// header occupies six bytes, data starts right after
	localparam int unsigned HDR_BYTES = 6;
	localparam int unsigned POS_W     = 9;

	// width of the portion counter
	localparam int unsigned COUNT_BITS = 32;
	localparam int unsigned TOTAL_W    = 32;

	// frame status codes
	localparam logic [1:0] ST_VALID    = 2'd0;
	localparam logic [1:0] ST_CSUM_ERR = 2'd1;
	localparam logic [1:0] ST_HDR_ERR  = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TARGET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_SOURCE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_COMMAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PORTION_INDEX = 3'd3;

	// configuration reset values
	localparam logic [7:0] RST_ACK_TARGET    = 8'h03;
	localparam logic [7:0] RST_ACK_SOURCE    = 8'h07;
	localparam logic [7:0] RST_ACK_COMMAND   = 8'h00;
	localparam logic [7:0] RST_PORTION_INDEX = 8'h07;

	typedef struct packed {
		logic [7:0] ack_target;
		logic [7:0] ack_source;
		logic [7:0] ack_command;
		logic [7:0] portion_index;
	} sfr_cfg_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         frame_target;
		logic [7:0]         frame_source;
		logic [7:0]         frame_command;
		logic [7:0]         frame_length;
		logic               is_ack;
		logic [7:0]         acked_portions;
		logic [TOTAL_W-1:0] portion_total;
	} sfr_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfr_ifs.sv
// ----------------------------------------------------------------------------
// sfr channel interfaces
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  frame_target;
	logic [7:0]  frame_source;
	logic [7:0]  frame_command;
	logic [7:0]  frame_length;
	logic        is_ack;
	logic [7:0]  acked_portions;
	logic [31:0] portion_total;

	modport source (
		output valid, output status, output frame_target, output frame_source,
		output frame_command, output frame_length, output is_ack,
		output acked_portions, output portion_total, input ready
	);
	modport sink (
		input valid, input status, input frame_target, input frame_source,
		input frame_command, input frame_length, input is_ack,
		input acked_portions, input portion_total, output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser: frame state tracker
// Advances the frame state by one byte per transfer and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parser
	import sfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  rx_byte,
	input  wire sfr_cfg_t    cfg,
	output logic             res_valid,
	output sfr_result_t      res
);

	logic [POS_W-1:0]      held_q, held_n;
	logic [7:0]            second_q, second_n;
	logic [7:0]            target_q, target_n;
	logic [7:0]            source_q, source_n;
	logic [7:0]            command_q, command_n;
	logic [7:0]            length_q, length_n;
	logic [7:0]            sum_q, sum_n;
	logic [7:0]            portion_q, portion_n;
	logic [COUNT_BITS-1:0] total_q, total_n;

	logic [POS_W-1:0] end_pos;
	logic [POS_W-1:0] portion_pos;
	logic [7:0]       sum_add;
	logic             ack_match;
	logic             clear;

	assign end_pos     = POS_W'(HDR_BYTES) + POS_W'(length_q);
	assign portion_pos = POS_W'(HDR_BYTES) + POS_W'(cfg.portion_index);
	assign sum_add     = sum_q + rx_byte;
	assign ack_match   = (target_q == cfg.ack_target) && (source_q == cfg.ack_source)
		&& (command_q == cfg.ack_command) && (cfg.portion_index < length_q);

	always_comb begin
		held_n    = held_q;
		second_n  = second_q;
		target_n  = target_q;
		source_n  = source_q;
		command_n = command_q;
		length_n  = length_q;
		sum_n     = sum_q;
		portion_n = portion_q;
		total_n   = total_q;
		clear     = 1'b0;
		res_valid = 1'b0;

		res.status         = ST_VALID;
		res.frame_target   = target_q;
		res.frame_source   = source_q;
		res.frame_command  = command_q;
		res.frame_length   = length_q;
		res.is_ack         = 1'b0;
		res.acked_portions = 8'h00;
		res.portion_total  = TOTAL_W'(total_q);

		if (held_q == '0) begin
			// hunting for sync
			if (rx_byte == SYNC_BYTE) begin
				sum_n  = SYNC_BYTE;
				held_n = POS_W'(1);
			end
		end else if (held_q < POS_W'(HDR_BYTES)) begin
			case (held_q[2:0])
				3'd1:    second_n  = rx_byte;
				3'd2:    target_n  = rx_byte;
				3'd3:    source_n  = rx_byte;
				3'd4:    command_n = rx_byte;
				default: length_n  = rx_byte;
			endcase
			sum_n  = sum_add;
			held_n = held_q + POS_W'(1);
			if (held_q == POS_W'(HDR_BYTES - 1) && second_q != SECOND_BYTE) begin
				res_valid        = 1'b1;
				res.status       = ST_HDR_ERR;
				res.frame_length = rx_byte;
				clear            = 1'b1;
			end
		end else if (held_q == end_pos) begin
			// checksum byte closes the frame
			res_valid = 1'b1;
			clear     = 1'b1;
			if (rx_byte != sum_q) begin
				res.status = ST_CSUM_ERR;
			end else if (ack_match) begin
				total_n            = total_q + COUNT_BITS'(portion_q);
				res.is_ack         = 1'b1;
				res.acked_portions = portion_q;
				res.portion_total  = TOTAL_W'(total_n);
			end
		end else begin
			if (held_q == portion_pos) begin
				portion_n = rx_byte;
			end
			sum_n  = sum_add;
			held_n = held_q + POS_W'(1);
		end

		if (clear) begin
			held_n    = '0;
			second_n  = '0;
			target_n  = '0;
			source_n  = '0;
			command_n = '0;
			length_n  = '0;
			sum_n     = '0;
			portion_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			second_q  <= '0;
			target_q  <= '0;
			source_q  <= '0;
			command_q <= '0;
			length_q  <= '0;
			sum_q     <= '0;
			portion_q <= '0;
			total_q   <= '0;
		end else if (accept) begin
			held_q    <= held_n;
			second_q  <= second_n;
			target_q  <= target_n;
			source_q  <= source_n;
			command_q <= command_n;
			length_q  <= length_n;
			sum_q     <= sum_n;
			portion_q <= portion_n;
			total_q   <= total_n;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_out_buf.sv
// ----------------------------------------------------------------------------
// sfr_out_buf: result register with skid stage
// Holds up to two results so the byte side keeps moving under a short stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_buf
	import sfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire sfr_result_t push_data,
	output logic             space,
	output logic             out_valid,
	input  wire logic        out_ready,
	output sfr_result_t      out_data
);

	logic        main_vld_q, skid_vld_q;
	sfr_result_t main_q, skid_q;
	logic        pop;

	assign pop       = main_vld_q && out_ready;
	assign space     = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				// skid drains into the main slot, no push can happen now
				if (pop) begin
					skid_vld_q <= 1'b0;
				end
			end else if (push) begin
				if (main_vld_q && !pop) begin
					skid_vld_q <= 1'b1;
				end else begin
					main_vld_q <= 1'b1;
				end
			end else if (pop) begin
				main_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_vld_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/serial_frame_receiver_ack_counter.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_ack_counter: framed serial receiver with ack counter
// Parses sync/header/length/checksum frames and counts acknowledged portions.
// ----------------------------------------------------------------------------
// usage
//   rx_in carries one received byte per transfer. bytes are hunted for the
//   0x55 sync, then header, data and checksum are taken in order.
//   res_out carries one result per frame end: status, header bytes, ack flag,
//   the portion byte added and the running portion total.
//   a frame with a bad second header byte ends right at its length byte.
//   the config port writes ack target, source, command and portion index;
//   writes to unused indexes are dropped. writes take effect once registered.
// timing
//   one byte is taken every cycle while rx_in.ready is high; the whole step
//   runs between the frame state registers and the result register, so the
//   closing byte transfer's result is registered before it shows on res_out.
// reset
//   arst_n clears the frame state, the portion total and both result slots,
//   and loads the config registers with their defaults.
// stall
//   a result register plus a skid slot keep bytes flowing; rx_in.ready drops
//   only while the skid slot is full, i.e. two results wait on res_out.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_ack_counter
	import sfr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	sfr_byte_if.sink                  rx_in,
	sfr_result_if.source              res_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_wdata
);

	sfr_cfg_t    cfg_q;
	sfr_result_t res;
	sfr_result_t out_data;
	logic        res_valid;
	logic        space;
	logic        accept;

	// byte transfer happens whenever the skid slot can catch a result
	assign rx_in.ready = space;
	assign accept      = rx_in.valid && space;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_target    <= RST_ACK_TARGET;
			cfg_q.ack_source    <= RST_ACK_SOURCE;
			cfg_q.ack_command   <= RST_ACK_COMMAND;
			cfg_q.portion_index <= RST_PORTION_INDEX;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACK_TARGET:    cfg_q.ack_target    <= cfg_wdata;
				CFG_ACK_SOURCE:    cfg_q.ack_source    <= cfg_wdata;
				CFG_ACK_COMMAND:   cfg_q.ack_command   <= cfg_wdata;
				CFG_PORTION_INDEX: cfg_q.portion_index <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame state and result forming
	sfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_in.rx_byte),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register and skid
	sfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.out_data  (out_data)
	);

	assign res_out.status         = out_data.status;
	assign res_out.frame_target   = out_data.frame_target;
	assign res_out.frame_source   = out_data.frame_source;
	assign res_out.frame_command  = out_data.frame_command;
	assign res_out.frame_length   = out_data.frame_length;
	assign res_out.is_ack         = out_data.is_ack;
	assign res_out.acked_portions = out_data.acked_portions;
	assign res_out.portion_total  = out_data.portion_total;

endmodule

`default_nettype wire

FILE: sim/sfr_frame_checker.sv
// ----------------------------------------------------------------------------
// sfr_frame_checker: result checker for the serial frame receiver
// Watches the byte, result and config ports, predicts each frame result
// and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module sfr_frame_checker
	import sfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	sfr_byte_if                  rx,
	sfr_result_if                res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata,
	output int                   mismatches,
	output int                   outstanding,
	output bit                   mid_frame,
	output int                   bytes_seen,
	output int                   frames_valid,
	output int                   frames_acked,
	output int                   frames_csum_bad,
	output int                   frames_hdr_bad
);

	// predicted receiver state
	sfr_cfg_t    regs;
	logic [8:0]  held;
	logic [7:0]  second, tgt, src, cmd, len, sum, portion;
	logic [31:0] total;

	sfr_result_t frames_due[$];
	sfr_result_t got;
	int          results_seen;

	function automatic sfr_result_t frame_result(logic [1:0] st, logic ack, logic [7:0] added);
		sfr_result_t r;
		r.status         = st;
		r.frame_target   = tgt;
		r.frame_source   = src;
		r.frame_command  = cmd;
		r.frame_length   = len;
		r.is_ack         = ack;
		r.acked_portions = added;
		r.portion_total  = total;
		return r;
	endfunction

	// append a predicted result at the tail of the queue
	task automatic expect_frame(input sfr_result_t r);
		frames_due.insert(frames_due.size(), r);
	endtask

	task automatic clear_frame();
		held    = '0;
		second  = '0;
		tgt     = '0;
		src     = '0;
		cmd     = '0;
		len     = '0;
		sum     = '0;
		portion = '0;
	endtask

	task automatic take_byte(input logic [7:0] b);
		if (held == 0) begin
			// hunting: only the sync byte opens a frame
			if (b == SYNC_BYTE) begin
				sum  = SYNC_BYTE;
				held = 9'd1;
			end
		end else if (held < HDR_BYTES) begin
			case (held)
				9'd1: second = b;
				9'd2: tgt = b;
				9'd3: src = b;
				9'd4: cmd = b;
				default: len = b;
			endcase
			sum  = sum + b;
			held = held + 9'd1;
			if (held == HDR_BYTES && second != SECOND_BYTE) begin
				expect_frame(frame_result(ST_HDR_ERR, 1'b0, 8'h00));
				clear_frame();
			end
		end else if (held == HDR_BYTES + len) begin
			// closing checksum byte
			if (b != sum) begin
				expect_frame(frame_result(ST_CSUM_ERR, 1'b0, 8'h00));
			end else if (tgt == regs.ack_target && src == regs.ack_source &&
			             cmd == regs.ack_command && regs.portion_index < len) begin
				total = total + 32'(portion);
				expect_frame(frame_result(ST_VALID, 1'b1, portion));
			end else begin
				expect_frame(frame_result(ST_VALID, 1'b0, 8'h00));
			end
			clear_frame();
		end else begin
			if (held - HDR_BYTES == regs.portion_index)
				portion = b;
			sum  = sum + b;
			held = held + 9'd1;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] seen,
	                             input logic [31:0] want);
		$display("sfr_frame_checker: result %0d %s: got 0x%0h, expected 0x%0h",
		         results_seen, what, seen, want);
		mismatches++;
	endtask

	task automatic check_frame(input sfr_result_t r);
		sfr_result_t want;
		if (frames_due.size() == 0) begin
			flag_mismatch("with nothing expected, status", 32'(r.status), 32'd0);
		end else begin
			want = frames_due.pop_front();
			if (r.status != want.status)
				flag_mismatch("status", 32'(r.status), 32'(want.status));
			if (r.frame_target != want.frame_target)
				flag_mismatch("frame_target", 32'(r.frame_target),
				              32'(want.frame_target));
			if (r.frame_source != want.frame_source)
				flag_mismatch("frame_source", 32'(r.frame_source),
				              32'(want.frame_source));
			if (r.frame_command != want.frame_command)
				flag_mismatch("frame_command", 32'(r.frame_command),
				              32'(want.frame_command));
			if (r.frame_length != want.frame_length)
				flag_mismatch("frame_length", 32'(r.frame_length),
				              32'(want.frame_length));
			if (r.is_ack != want.is_ack)
				flag_mismatch("is_ack", 32'(r.is_ack), 32'(want.is_ack));
			if (r.acked_portions != want.acked_portions)
				flag_mismatch("acked_portions", 32'(r.acked_portions),
				              32'(want.acked_portions));
			if (r.portion_total != want.portion_total)
				flag_mismatch("portion_total", r.portion_total, want.portion_total);
		end
		case (r.status)
			ST_VALID:    frames_valid++;
			ST_CSUM_ERR: frames_csum_bad++;
			default:     frames_hdr_bad++;
		endcase
		if (r.is_ack)
			frames_acked++;
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.ack_target    = RST_ACK_TARGET;
			regs.ack_source    = RST_ACK_SOURCE;
			regs.ack_command   = RST_ACK_COMMAND;
			regs.portion_index = RST_PORTION_INDEX;
			clear_frame();
			total = '0;
			frames_due.delete();
		end else begin
			// results leaving now stem from earlier bytes, so check them first
			if (res.valid && res.ready) begin
				got.status         = res.status;
				got.frame_target   = res.frame_target;
				got.frame_source   = res.frame_source;
				got.frame_command  = res.frame_command;
				got.frame_length   = res.frame_length;
				got.is_ack         = res.is_ack;
				got.acked_portions = res.acked_portions;
				got.portion_total  = res.portion_total;
				check_frame(got);
			end
			// a byte taken at this edge still sees the old registers
			if (rx.valid && rx.ready) begin
				take_byte(rx.rx_byte);
				bytes_seen++;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACK_TARGET:    regs.ack_target = cfg_wdata;
					CFG_ACK_SOURCE:    regs.ack_source = cfg_wdata;
					CFG_ACK_COMMAND:   regs.ack_command = cfg_wdata;
					CFG_PORTION_INDEX: regs.portion_index = cfg_wdata;
					default: ;
				endcase
			end
		end
		outstanding <= frames_due.size();
		mid_frame   <= (held != 0);
	end

endmodule

FILE: sim/serial_frame_receiver_ack_counter_tb.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_ack_counter_tb: top of the receiver testbench
// Feeds byte streams of framed and noisy traffic under several ack register
// settings, with random idle and stall on both channels, and lets a checker
// module compare every frame result. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module serial_frame_receiver_ack_counter_tb;
	import sfr_pkg::*;

	localparam int PHASES      = 8;        // config settings run in turn
	localparam int PHASE_BYTES = 190;      // byte transfers per setting
	localparam int HOLD_CYCLES = 300;      // long result hold-off
	localparam int TIME_LIMIT  = 2000000;  // watchdog, in time units

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;

	sfr_byte_if   rx_ch();
	sfr_result_if res_ch();

	// checker outputs
	int mismatches, outstanding, bytes_seen;
	int frames_valid, frames_acked, frames_csum_bad, frames_hdr_bad;
	bit mid_frame;

	// stimulus side copy of the ack registers, used to build matching frames
	logic [7:0] ack_tgt, ack_src, ack_cmd;
	bit         tx_steady;      // stretch of back to back bytes
	bit         tx_rush;        // forced back to back bytes during the hold-off
	int         bytes_sent;
	int         hold_requests;  // bumped to ask the result side for a hold-off

	serial_frame_receiver_ack_counter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_in     (rx_ch),
		.res_out   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	sfr_frame_checker frame_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx_ch),
		.res             (res_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.mid_frame       (mid_frame),
		.bytes_seen      (bytes_seen),
		.frames_valid    (frames_valid),
		.frames_acked    (frames_acked),
		.frames_csum_bad (frames_csum_bad),
		.frames_hdr_bad  (frames_hdr_bad)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake or a missing result ends here
	initial begin
		#TIME_LIMIT;
		$display("serial_frame_receiver_ack_counter_tb: errors");
		$finish;
	end

	// one byte transfer, after a random idle gap
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_steady = !tx_steady;
		gap = (tx_steady || tx_rush) ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		// valid stays up until the transfer; ready may drop when results back up
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	// a full frame; a bad second byte ends it at the length byte.
	// fill < 0 gives random data, otherwise every data byte is fill
	task automatic send_frame(input logic [7:0] second, tgt, src, cmd, len,
	                          input bit csum_ok, input int fill);
		logic [7:0] sum, d;
		sum = SYNC_BYTE + second + tgt + src + cmd + len;
		push_byte(SYNC_BYTE);
		push_byte(second);
		push_byte(tgt);
		push_byte(src);
		push_byte(cmd);
		push_byte(len);
		if (second != SECOND_BYTE)
			return;
		for (int i = 0; i < len; i++) begin
			d   = (fill < 0) ? 8'($urandom) : 8'(fill);
			sum = sum + d;
			push_byte(d);
		end
		push_byte(csum_ok ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	// mostly well formed frames, some aimed at the ack registers,
	// with stray bytes, bad headers and bad checksums mixed in
	task automatic random_frame();
		logic [7:0] second, tgt, src, cmd, len;
		int noise;
		noise = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		repeat (noise) push_byte(8'($urandom));
		second = SECOND_BYTE;
		if ($urandom_range(0, 99) < 8) begin
			second = 8'($urandom);
			if (second == SECOND_BYTE)
				second = 8'h00;
		end
		if ($urandom_range(0, 1)) begin
			{tgt, src, cmd} = {ack_tgt, ack_src, ack_cmd};
		end else begin
			tgt = $urandom_range(0, 1) ? ack_tgt : 8'($urandom);
			src = $urandom_range(0, 1) ? ack_src : 8'($urandom);
			cmd = $urandom_range(0, 1) ? ack_cmd : 8'($urandom);
		end
		// short payloads keep the portion index near the frame end
		len = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(13, 80))
		                                   : 8'($urandom_range(0, 12));
		send_frame(second, tgt, src, cmd, len, $urandom_range(0, 9) != 0, -1);
	endtask

	// let the receiver fall back to hunting and drain every result.
	// zero bytes close whatever frame stray bytes may have opened
	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (mid_frame) begin
			push_byte(8'h00);
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		while (outstanding != 0) @(posedge clk);
		// the result register sits behind the closing byte transfer
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// all four registers, then a write to an unused index that must be dropped
	task automatic load_regs(input logic [7:0] tgt, src, cmd, pidx);
		cfg_put(CFG_ACK_TARGET, tgt);
		cfg_put(CFG_ACK_SOURCE, src);
		cfg_put(CFG_ACK_COMMAND, cmd);
		cfg_put(CFG_PORTION_INDEX, pidx);
		cfg_put(CFG_IDX_W'($urandom_range(CFG_PORTION_INDEX + 1, (1 << CFG_IDX_W) - 1)),
		        8'($urandom));
		cfg_we <= 1'b0;
		{ack_tgt, ack_src, ack_cmd} = {tgt, src, cmd};
	endtask

	// result side: random stalls, steady stretches, and one long hold-off
	initial begin
		int stall;
		int holds_done;
		bit steady;
		res_ch.ready = 1'b0;
		holds_done   = 0;
		steady       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_requests != holds_done) begin
				// sender keeps going, so the result slots fill and rx stalls
				holds_done++;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 5);
			repeat (stall) begin
				res_ch.ready <= 1'b0;
				@(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// stimulus and verdict
	initial begin
		int phase_end;
		logic [7:0] bad;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = 8'h00;
		ack_tgt       = RST_ACK_TARGET;
		ack_src       = RST_ACK_SOURCE;
		ack_cmd       = RST_ACK_COMMAND;
		tx_steady     = 1'b0;
		tx_rush       = 1'b0;
		bytes_sent    = 0;
		hold_requests = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset register values
		// stray bytes while hunting are dropped
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(SECOND_BYTE);
		// bad second header byte, header fields at their extremes
		send_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, -1);
		// ack frame whose portion byte is the largest value
		send_frame(SECOND_BYTE, RST_ACK_TARGET, RST_ACK_SOURCE, RST_ACK_COMMAND, 8'd8,
		           1'b1, 8'hFF);
		// zero length: checksum right after the length byte, here a wrong one
		send_frame(SECOND_BYTE, RST_ACK_TARGET, RST_ACK_SOURCE, RST_ACK_COMMAND, 8'd0,
		           1'b0, -1);

		for (int ph = 0; ph < PHASES; ph++) begin
			// registers change only with the receiver hunting and drained
			if (ph != 0) begin
				settle();
				case (ph)
					1: load_regs(8'h00, 8'h00, 8'h00, 8'h00);
					2: load_regs(8'hFF, 8'hFF, 8'hFF, 8'd254);
					default: load_regs(8'($urandom), 8'($urandom), 8'($urandom),
					                   8'($urandom_range(0, 12)));
				endcase
			end
			phase_end = bytes_sent + PHASE_BYTES;
			if (ph == 2) begin
				// longest payload: the portion sits in the last data byte
				send_frame(SECOND_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'd255, 1'b1, -1);
				// one short of it: matching but too short to count
				send_frame(SECOND_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'd254, 1'b1, -1);
			end
			if (ph == 3) begin
				// back to back short frames against a held result port
				hold_requests <= hold_requests + 1;
				tx_rush = 1'b1;
				repeat (16) begin
					bad = 8'($urandom);
					if (bad == SECOND_BYTE)
						bad = 8'h00;
					send_frame(bad, 8'($urandom), 8'($urandom), 8'($urandom),
					           8'($urandom), 1'b1, -1);
				end
				tx_rush = 1'b0;
			end
			while (bytes_sent < phase_end)
				random_frame();
		end

		settle();
		repeat (10) @(posedge clk);

		$display("run covered %0d byte transfers over %0d register settings, one long hold-off",
		         bytes_seen, PHASES);
		$display("frames: %0d valid (%0d counted as ack), %0d checksum errors, %0d header errors",
		         frames_valid, frames_acked, frames_csum_bad, frames_hdr_bad);
		if (mismatches == 0 && outstanding == 0)
			$display("serial_frame_receiver_ack_counter_tb: clean");
		else
			$display("serial_frame_receiver_ack_counter_tb: errors");
		$finish;
	end

endmodule
